>>> rtl/scm_pkg.sv
// ============================================================================
// scm_pkg: shared types and constants for the stereo correlation meter
// Holds the payload structs, register indexes and controller/datapath links.
// ============================================================================
package scm_pkg;

    localparam int SampleBits = 24;
    localparam int FracBits   = 16;
    localparam int AvgBits    = 64;
    localparam int CfgIdxBits = 2;
    localparam int CfgBits    = 16;

    localparam logic [CfgIdxBits-1:0] CFG_COEF   = 2'd0;
    localparam logic [CfgIdxBits-1:0] CFG_FLOOR  = 2'd1;
    localparam logic [CfgIdxBits-1:0] CFG_ENABLE = 2'd2;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic               publish;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] correlation_q15;
        logic signed [15:0] balance_q15;
        logic [23:0]        mid_level;
        logic [23:0]        side_level;
        logic [23:0]        left_level;
        logic [23:0]        right_level;
    } t_out_item;

    // Datapath operations chosen by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PROD, OP_SMOOTH, OP_SQRT_INIT, OP_SQRT_STEP,
        OP_SQRT_SAVE, OP_ENERGY, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_SAVE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] sel;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

endpackage

>>> rtl/scm_datapath.sv
// ============================================================================
// scm_datapath: averages, shared square root and shared Q1.15 divider
// One unit of each kind; the controller steps them through an item.
// ============================================================================
module scm_datapath
    import scm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    input  t_in_item     i_item,
    input  logic [15:0]  i_coef,
    input  logic [15:0]  i_floor,
    output t_status      o_status,
    output t_out_item    o_result
);

    logic signed [63:0] r_avg [6];
    logic signed [24:0] r_a;
    logic signed [24:0] r_b;
    logic signed [49:0] r_prod;
    logic signed [23:0] r_l;
    logic signed [23:0] r_r;

    // Square root unit, one result bit per bit pair, one pair a step.
    logic [63:0] r_sx;
    logic [63:0] r_sr;
    logic [63:0] r_sbit;
    logic        r_sbusy;
    logic [31:0] r_rt [6];

    // Divider unit, one quotient bit a step.
    logic [63:0] r_dr;
    logic [63:0] r_dden;
    logic [14:0] r_dq;
    logic        r_dneg;
    logic        r_dsat;
    logic [63:0] r_energy;
    logic [63:0] r_total;
    logic        r_csil;
    logic        r_bsil;
    logic signed [15:0] r_corr;
    logic signed [15:0] r_bal;

    logic signed [63:0] w_target;
    logic signed [63:0] w_d;
    logic signed [63:0] w_hi;
    logic [15:0]        w_lo;
    logic signed [80:0] w_hic;
    logic [31:0]        w_loc;
    logic [63:0]        w_sqin;
    logic [63:0]        w_sum;
    logic signed [63:0] w_num;
    logic [63:0]        w_mag;
    logic [63:0]        w_den;
    logic [63:0]        w_rsh;

    always_comb begin
        if (i_cmd.sel < 3'd3) begin
            w_target = 64'(r_prod) <<< FracBits;
        end else begin
            w_target = 64'(r_prod) <<< (FracBits - 2);
        end
        w_d   = w_target - r_avg[i_cmd.sel];
        w_hi  = w_d >>> 16;
        w_lo  = w_d[15:0];
        w_hic = 81'(w_hi) * $signed({1'b0, i_coef});
        w_loc = 32'(w_lo) * 32'(i_coef);
        case (i_cmd.sel)
            3'd0:    w_sqin = r_avg[1][63] ? 64'd0 : r_avg[1];
            3'd1:    w_sqin = r_avg[2][63] ? 64'd0 : r_avg[2];
            3'd2:    w_sqin = r_avg[4][63] ? 64'd0 : 64'(r_avg[4] >>> FracBits);
            3'd3:    w_sqin = r_avg[5][63] ? 64'd0 : 64'(r_avg[5] >>> FracBits);
            3'd4:    w_sqin = r_avg[1][63] ? 64'd0 : 64'(r_avg[1] >>> FracBits);
            default: w_sqin = r_avg[2][63] ? 64'd0 : 64'(r_avg[2] >>> FracBits);
        endcase
        w_sum = r_sr + r_sbit;
        if (i_cmd.sel == 3'd0) begin
            w_num = r_avg[0];
            w_den = r_energy;
        end else begin
            w_num = 64'({32'd0, r_rt[1]}) - 64'({32'd0, r_rt[0]});
            w_den = r_total;
        end
        w_mag = w_num[63] ? 64'(-w_num) : w_num;
        w_rsh = {r_dr[62:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_avg[i] <= '0;
            end
            r_sbusy <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_l <= i_item.left_sample;
                    r_r <= i_item.right_sample;
                end
                OP_PROD: begin
                    case (i_cmd.sel)
                        3'd0: begin r_a <= 25'(r_l); r_b <= 25'(r_r); end
                        3'd1: begin r_a <= 25'(r_l); r_b <= 25'(r_l); end
                        3'd2: begin r_a <= 25'(r_r); r_b <= 25'(r_r); end
                        3'd3: begin r_a <= 25'(r_l) + 25'(r_r);
                                    r_b <= 25'(r_l) - 25'(r_r); end
                        3'd4: begin r_a <= 25'(r_l) + 25'(r_r);
                                    r_b <= 25'(r_l) + 25'(r_r); end
                        default: begin r_a <= 25'(r_l) - 25'(r_r);
                                       r_b <= 25'(r_l) - 25'(r_r); end
                    endcase
                end
                OP_SMOOTH: begin
                    r_avg[i_cmd.sel] <= r_avg[i_cmd.sel] + 64'(w_hic)
                        + 64'({32'd0, w_loc[31:16]});
                end
                OP_SQRT_INIT: begin
                    r_sx    <= w_sqin;
                    r_sr    <= '0;
                    r_sbit  <= 64'h4000_0000_0000_0000;
                    r_sbusy <= 1'b1;
                end
                OP_SQRT_STEP: begin
                    if (r_sbit == 64'd0) begin
                        r_sbusy <= 1'b0;
                    end else begin
                        if (r_sx >= w_sum) begin
                            r_sx <= r_sx - w_sum;
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end
                OP_SQRT_SAVE: r_rt[i_cmd.sel] <= r_sr[31:0];
                OP_ENERGY: begin
                    r_energy <= 64'(r_rt[0]) * 64'(r_rt[1]);
                    r_total  <= 64'(r_rt[0]) + 64'(r_rt[1]);
                end
                OP_DIV_INIT: begin
                    r_dneg <= w_num[63];
                    r_dsat <= (w_mag >= w_den);
                    r_dr   <= w_mag;
                    r_dden <= w_den;
                    r_dq   <= '0;
                    r_csil <= (r_energy == 64'd0) || (r_energy < 64'(i_floor));
                    r_bsil <= (r_total == 64'd0) || (r_total <= 64'(i_floor));
                end
                OP_DIV_STEP: begin
                    if (w_rsh >= r_dden || r_dr[63]) begin
                        r_dr <= w_rsh - r_dden;
                        r_dq <= {r_dq[13:0], 1'b1};
                    end else begin
                        r_dr <= w_rsh;
                        r_dq <= {r_dq[13:0], 1'b0};
                    end
                end
                OP_DIV_SAVE: begin
                    if (i_cmd.sel == 3'd0) begin
                        if (r_csil) r_corr <= 16'sd32767;
                        else if (r_dsat) r_corr <= r_dneg ? 16'sh8000 : 16'sd32767;
                        else r_corr <= r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                    end else begin
                        if (r_bsil) r_bal <= '0;
                        else if (r_dsat) r_bal <= r_dneg ? 16'sh8000 : 16'sd32767;
                        else r_bal <= r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == OP_PROD) begin
                r_prod <= r_prod;
            end else begin
                r_prod <= r_a * r_b;
            end
        end
    end

    assign o_status.busy = r_sbusy;
    assign o_result.correlation_q15 = r_corr;
    assign o_result.balance_q15     = r_bal;
    assign o_result.mid_level       = r_rt[2][23:0];
    assign o_result.side_level      = r_rt[3][23:0];
    assign o_result.left_level      = r_rt[4][23:0];
    assign o_result.right_level     = r_rt[5][23:0];

endmodule

>>> rtl/scm_ctrl.sv
// ============================================================================
// scm_ctrl: sequencer for the stereo correlation meter
// Runs the six average updates, then on publish the roots and divisions.
// ============================================================================
module scm_ctrl
    import scm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_publish,
    input  logic      i_enable,
    input  logic      i_out_stall,
    input  t_status   i_status,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_MUL, S_SMOOTH, S_SQ_INIT, S_SQ_RUN, S_SQ_SAVE,
        S_ENERGY, S_DIV_INIT, S_DIV_RUN, S_DIV_SAVE, S_OUT
    } t_state;

    t_state     r_state;
    logic [2:0] r_sel;
    logic       r_pub;
    logic       r_out_valid;
    logic [3:0] r_cnt;

    // While analysis is off, samples are still taken in and simply dropped.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE:     o_cmd.op = (i_in_valid && i_enable) ? OP_LOAD : OP_NONE;
            S_PROD:     o_cmd.op = OP_PROD;
            S_SMOOTH:   o_cmd.op = OP_SMOOTH;
            S_SQ_INIT:  o_cmd.op = OP_SQRT_INIT;
            S_SQ_RUN:   o_cmd.op = OP_SQRT_STEP;
            S_SQ_SAVE:  o_cmd.op = OP_SQRT_SAVE;
            S_ENERGY:   o_cmd.op = OP_ENERGY;
            S_DIV_INIT: o_cmd.op = OP_DIV_INIT;
            S_DIV_RUN:  o_cmd.op = OP_DIV_STEP;
            S_DIV_SAVE: o_cmd.op = OP_DIV_SAVE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= '0;
            r_pub       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_enable) begin
                        r_pub   <= i_publish;
                        r_sel   <= '0;
                        r_state <= S_PROD;
                    end
                end
                S_PROD:   r_state <= S_MUL;
                S_MUL:    r_state <= S_SMOOTH;
                S_SMOOTH: begin
                    if (r_sel == 3'd5) begin
                        r_sel   <= '0;
                        r_state <= r_pub ? S_SQ_INIT : S_IDLE;
                    end else begin
                        r_sel   <= r_sel + 3'd1;
                        r_state <= S_PROD;
                    end
                end
                S_SQ_INIT: r_state <= S_SQ_RUN;
                S_SQ_RUN:  if (!i_status.busy) r_state <= S_SQ_SAVE;
                S_SQ_SAVE: begin
                    if (r_sel == 3'd5) begin
                        r_sel   <= '0;
                        r_state <= S_ENERGY;
                    end else begin
                        r_sel   <= r_sel + 3'd1;
                        r_state <= S_SQ_INIT;
                    end
                end
                S_ENERGY:   r_state <= S_DIV_INIT;
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd14) r_state <= S_DIV_SAVE;
                end
                S_DIV_SAVE: begin
                    if (r_sel == 3'd1) begin
                        r_sel       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_sel   <= 3'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/stereo_correlation_meter.sv
// ============================================================================
// stereo_correlation_meter: stereo phase correlation and level meter
// Channel    Direction  Signals
// input      in         i_in_valid, o_in_stall, i_in_item
// result     out        o_out_valid, i_out_stall, o_out_item
// config     in         i_cfg_we, i_cfg_index, i_cfg_data
// A sample without publish runs six average updates through one multiplier.
// With publish, six square roots, one energy step and two divisions follow
// before the reading is offered. The block takes one
// item at a time and holds off input until the reading is transferred. While
// analysis is off, samples are taken in every cycle and dropped.
// Reset is synchronous and clears all averages.
// ============================================================================
module stereo_correlation_meter
    import scm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [CfgBits-1:0]    i_cfg_data
);

    logic [15:0] r_coef;
    logic [15:0] r_floor;
    logic        r_enable;
    t_cmd        w_cmd;
    t_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= 16'd3;
            r_floor  <= 16'd1;
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COEF:   r_coef   <= i_cfg_data;
                CFG_FLOOR:  r_floor  <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    scm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_publish   (i_in_item.publish),
        .i_enable    (r_enable),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    scm_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_in_item),
        .i_coef   (r_coef),
        .i_floor  (r_floor),
        .o_status (w_status),
        .o_result (o_out_item)
    );

endmodule

>>> rtl/scm_checker.sv
// ============================================================================
// scm_checker: port-level checks for the stereo correlation meter
// Watches the handshakes and the one-item-at-a-time behavior.
// ============================================================================
module scm_checker
    import scm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result waits");

    // A reading needs processing after the input transfer, so none is valid right after it.
    a_accept_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result right after an input transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind stereo_correlation_meter scm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> dv/tb_stereo_correlation_meter.sv
// ============================================================================
// tb_stereo_correlation_meter: self-checking bench for the correlation meter
// Drives stereo sample pairs through the valid/stall channel, tracks the six
// smoothed averages in a behavioral copy of the meter, and compares every
// published reading field by field against the oldest pending prediction.
// ============================================================================
module tb_stereo_correlation_meter;
    import scm_pkg::*;

    class meter_scoreboard;
        logic [15:0] coef;
        logic [15:0] floor_lvl;
        logic        enable;
        longint      avg_lr, avg_ll, avg_rr, avg_ms, avg_mm, avg_ss;
        t_out_item   pending[$];
        int          errors;
        int          readings;

        function void clear();
            coef = 16'd3;
            floor_lvl = 16'd1;
            enable = 1'b1;
            avg_lr = 0; avg_ll = 0; avg_rr = 0;
            avg_ms = 0; avg_mm = 0; avg_ss = 0;
            errors = 0;
            readings = 0;
        endfunction

        function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
            if (idx == CFG_COEF) coef = val;
            else if (idx == CFG_FLOOR) floor_lvl = val;
            else if (idx == CFG_ENABLE) enable = val[0];
        endfunction

        // Split d into a floored high part and a nonnegative low part so that
        // the coefficient product never overflows 64 bits.
        function longint smooth(longint acc, longint target);
            longint d, hi, lo, c;
            d = target - acc;
            c = longint'(coef);
            hi = d >>> 16;
            lo = d - hi * 65536;
            return acc + hi * c + (lo * c) / 65536;
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned pos(longint v);
            return v > 0 ? longint'(v) : 0;
        endfunction

        function logic [15:0] ratio_q15(longint num, longint unsigned den);
            longint unsigned mag, r, q;
            logic neg;
            neg = num < 0;
            mag = neg ? -num : num;
            if (mag >= den) return neg ? 16'h8000 : 16'h7fff;
            r = mag;
            q = 0;
            for (int i = 0; i < 15; i++) begin
                r <<= 1;
                q <<= 1;
                if (r >= den) begin
                    r -= den;
                    q |= 1;
                end
            end
            return neg ? 16'(-q) : 16'(q);
        endfunction

        function void note_sample(t_in_item it);
            longint l, r, m2, s2;
            longint unsigned rl, rr, energy, total;
            t_out_item o;
            if (!enable) return;
            l = it.left_sample;
            r = it.right_sample;
            m2 = l + r;
            s2 = l - r;
            avg_lr = smooth(avg_lr, l * r * 65536);
            avg_ll = smooth(avg_ll, l * l * 65536);
            avg_rr = smooth(avg_rr, r * r * 65536);
            avg_ms = smooth(avg_ms, m2 * s2 * 16384);
            avg_mm = smooth(avg_mm, m2 * m2 * 16384);
            avg_ss = smooth(avg_ss, s2 * s2 * 16384);
            if (!it.publish) return;
            rl = root(pos(avg_ll));
            rr = root(pos(avg_rr));
            energy = rl * rr;
            if (energy == 0 || energy < floor_lvl) o.correlation_q15 = 16'h7fff;
            else o.correlation_q15 = ratio_q15(avg_lr, energy);
            total = rl + rr;
            if (total == 0 || total <= floor_lvl) o.balance_q15 = '0;
            else o.balance_q15 = ratio_q15(longint'(rr) - longint'(rl), total);
            o.mid_level = 24'(root(pos(avg_mm) >> 16));
            o.side_level = 24'(root(pos(avg_ss) >> 16));
            o.left_level = 24'(root(pos(avg_ll) >> 16));
            o.right_level = 24'(root(pos(avg_rr) >> 16));
            pending.push_back(o);
        endfunction

        function void check_reading(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected reading %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            readings++;
            if (got.correlation_q15 !== e.correlation_q15) begin
                $error("correlation_q15 exp %0d got %0d", e.correlation_q15,
                       got.correlation_q15);
                errors++;
            end
            if (got.balance_q15 !== e.balance_q15) begin
                $error("balance_q15 exp %0d got %0d", e.balance_q15, got.balance_q15);
                errors++;
            end
            if (got.mid_level !== e.mid_level) begin
                $error("mid_level exp %0d got %0d", e.mid_level, got.mid_level);
                errors++;
            end
            if (got.side_level !== e.side_level) begin
                $error("side_level exp %0d got %0d", e.side_level, got.side_level);
                errors++;
            end
            if (got.left_level !== e.left_level) begin
                $error("left_level exp %0d got %0d", e.left_level, got.left_level);
                errors++;
            end
            if (got.right_level !== e.right_level) begin
                $error("right_level exp %0d got %0d", e.right_level, got.right_level);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0] i_cfg_index = '0;
    logic [CfgBits-1:0]    i_cfg_data = '0;

    meter_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int samples_sent = 0;

    stereo_correlation_meter dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stall, or a long counted hold-off when requested.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_reading(o_out_item);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Valid stays high after a transfer; the next send, drain or register
    // write takes it down, so it is driven only once per edge.
    task automatic send(logic signed [23:0] l, logic signed [23:0] r, logic pub);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{left_sample: l, right_sample: r, publish: pub};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(i_in_item);
        samples_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
        i_in_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_sample(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(511)) - 256);
            default: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    // A block of samples, related or independent, ending with a publish mark.
    task automatic random_block(int len);
        logic signed [23:0] l, r;
        int mode, rel;
        mode = $urandom_range(9) < 7 ? 0 : ($urandom_range(1) ? 1 : 2);
        rel = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            l = rand_sample(mode);
            case (rel)
                0: r = l;
                1: r = -l;
                2: r = rand_sample(mode);
                default: r = l >>> $urandom_range(8);
            endcase
            send(l, r, (i == len - 1) || ($urandom_range(19) == 0));
        end
    endtask

    task automatic random_phase(int blocks);
        for (int b = 0; b < blocks; b++) random_block($urandom_range(1, 12));
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at reset settings, then fast smoothing.
        send(24'sh7fffff, 24'sh7fffff, 1'b1);
        send(24'sh800000, 24'sh800000, 1'b1);
        send(24'sh7fffff, 24'sh800000, 1'b1);
        send(24'sh0, 24'sh0, 1'b1);
        drain();
        write_reg(CFG_COEF, 16'hffff);
        write_reg(CFG_FLOOR, 16'd0);
        send(24'sh7fffff, 24'sh800000, 1'b1);
        send(24'sh800000, 24'sh7fffff, 1'b0);
        send(24'sh000001, 24'sh000000, 1'b1);
        send(24'sh000000, 24'sh000000, 1'b1);
        send(24'sh400000, 24'sh000100, 1'b1);
        send(24'shffffff, 24'sh000001, 1'b1);
        drain();
        write_reg(CFG_FLOOR, 16'hffff);
        send(24'sh000400, 24'sh000200, 1'b1);
        send(24'sh7fffff, 24'sh7ffff0, 1'b1);
        drain();
        write_reg(CFG_ENABLE, 1'b0);
        send(24'sh123456, 24'sh654321, 1'b1);
        send(24'sh7fffff, 24'sh800000, 1'b0);
        drain();
        write_reg(CFG_ENABLE, 1'b1);
        write_reg(CFG_COEF, 16'd0);
        send(24'sh7fffff, 24'sh800000, 1'b1);
        drain();
        write_reg(CFG_COEF, 16'd1);
        write_reg(CFG_FLOOR, 16'd1);
        send(24'sh800000, 24'sh800000, 1'b1);
        drain();

        send_idle_pct = 33;
        recv_idle_pct = 58;
        write_reg(CFG_COEF, 16'h8000);
        random_phase(80);
        // Long receiver hold-off while samples keep arriving.
        hold_cycles = 3000;
        random_phase(8);
        drain();

        send_idle_pct = 58;
        recv_idle_pct = 33;
        write_reg(CFG_COEF, 16'($urandom_range(1, 65535)));
        write_reg(CFG_FLOOR, 16'($urandom_range(65535)));
        write_reg(CFG_ENABLE, 1'b0);
        random_block(3);
        write_reg(CFG_ENABLE, 1'b1);
        random_phase(80);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_COEF, 16'hffff);
        write_reg(CFG_FLOOR, 16'd0);
        while (samples_sent < 1700) random_block($urandom_range(1, 12));
        drain();

        $display("Sent %0d sample pairs over several smoothing and floor settings;",
                 samples_sent);
        $display("%0d readings compared, including long output back-pressure.",
                 sb.readings);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
